>>> design/sstf_pkg.sv
// shared types and constants of the sip server transaction block
`timescale 1ns / 1ps

package sstf_pkg;

   localparam int OP_W    = 3;
   localparam int CODE_W  = 10;
   localparam int KIND_W  = 2;
   localparam int PHASE_W = 2;
   localparam int T1_W    = 12;
   localparam int T2_W    = 15;
   localparam int T4_W    = 15;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int REG_W   = 3;

   // event operations
   localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
   localparam logic [OP_W-1:0] OP_RESPOND = 3'd1;
   localparam logic [OP_W-1:0] OP_RETRANS = 3'd2;
   localparam logic [OP_W-1:0] OP_ACK     = 3'd3;
   localparam logic [OP_W-1:0] OP_RESTART = 3'd4;

   // what to transmit
   localparam logic [KIND_W-1:0] SEND_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] SEND_GIVEN = 2'd1;
   localparam logic [KIND_W-1:0] SEND_PROV  = 2'd2;
   localparam logic [KIND_W-1:0] SEND_FINAL = 2'd3;

   // register indexes
   localparam logic [REG_W-1:0] REG_IS_INVITE  = 3'd0;
   localparam logic [REG_W-1:0] REG_UNRELIABLE = 3'd1;
   localparam logic [REG_W-1:0] REG_T1         = 3'd2;
   localparam logic [REG_W-1:0] REG_T2         = 3'd3;
   localparam logic [REG_W-1:0] REG_T4         = 3'd4;

   localparam logic [T1_W-1:0] T1_AT_RESET = 12'd500;
   localparam logic [T2_W-1:0] T2_AT_RESET = 15'd4000;
   localparam logic [T4_W-1:0] T4_AT_RESET = 15'd5000;

   typedef struct packed {
      logic            is_invite;
      logic            unreliable_transport;
      logic [T1_W-1:0] t1_ms;
      logic [T2_W-1:0] t2_ms;
      logic [T4_W-1:0] t4_ms;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0]  send_kind;
      logic [CODE_W-1:0]  send_code;
      logic [PHASE_W-1:0] txn_phase;
      logic               is_terminated;
      logic               terminated_now;
      logic               failed;
      logic               discarded;
   } result_type;

endpackage

>>> design/sstf_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface sstf_req_if import sstf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [CODE_W-1:0] status_code;

   modport source (output valid, output operation, output status_code, input ready);
   modport sink (input valid, input operation, input status_code, output ready);
endinterface

interface sstf_rsp_if import sstf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  send_kind;
   logic [CODE_W-1:0]  send_code;
   logic [PHASE_W-1:0] txn_phase;
   logic               is_terminated;
   logic               terminated_now;
   logic               failed;
   logic               discarded;

   modport source (output valid, output send_kind, output send_code, output txn_phase,
                   output is_terminated, output terminated_now, output failed,
                   output discarded, input ready);
   modport sink (input valid, input send_kind, input send_code, input txn_phase,
                 input is_terminated, input terminated_now, input failed,
                 input discarded, output ready);
endinterface

>>> design/sstf_csr.sv
// apb register file for the transaction settings
`timescale 1ns / 1ps

module sstf_csr import sstf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   cfg_type          cfg_ff;
   logic             wr_en;
   logic [REG_W-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[ADDR_W-1:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.is_invite            <= 1'b1;
         cfg_ff.unreliable_transport <= 1'b1;
         cfg_ff.t1_ms                <= T1_AT_RESET;
         cfg_ff.t2_ms                <= T2_AT_RESET;
         cfg_ff.t4_ms                <= T4_AT_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_IS_INVITE:  cfg_ff.is_invite <= csr_pwdata[0];
            REG_UNRELIABLE: cfg_ff.unreliable_transport <= csr_pwdata[0];
            REG_T1:         cfg_ff.t1_ms <= csr_pwdata[T1_W-1:0];
            REG_T2:         cfg_ff.t2_ms <= csr_pwdata[T2_W-1:0];
            REG_T4:         cfg_ff.t4_ms <= csr_pwdata[T4_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_IS_INVITE:  csr_prdata = DATA_W'(cfg_ff.is_invite);
         REG_UNRELIABLE: csr_prdata = DATA_W'(cfg_ff.unreliable_transport);
         REG_T1:         csr_prdata = DATA_W'(cfg_ff.t1_ms);
         REG_T2:         csr_prdata = DATA_W'(cfg_ff.t2_ms);
         REG_T4:         csr_prdata = DATA_W'(cfg_ff.t4_ms);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

>>> design/sstf_engine.sv
// transaction state, timers and result register
`timescale 1ns / 1ps

module sstf_engine import sstf_pkg::*; #(
   parameter int TIMER_BITS = 18
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [OP_W-1:0]   operation,
   input  logic [CODE_W-1:0] status_code,
   input  cfg_type           cfg,
   output result_type        result
);

   typedef enum logic [PHASE_W-1:0] {
      PH_PROCEEDING    = 2'd0,
      PH_NI_PROCEEDING = 2'd1,
      PH_COMPLETED     = 2'd2,
      PH_CONFIRMED     = 2'd3
   } phase_type;

   localparam int TMR_G = 0;
   localparam int TMR_H = 1;
   localparam int TMR_L = 2;
   localparam logic [31:0] TMAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

   phase_type             phase_ff, phase_in;
   logic                  ended_ff, ended_in;
   logic [CODE_W-1:0]     prov_ff, prov_in;
   logic [CODE_W-1:0]     final_ff, final_in;
   logic [T2_W-1:0]       interval_ff, interval_in;
   logic [T2_W-1:0]       remain_ff, remain_in;
   logic [TIMER_BITS-1:0] abandon_ff, abandon_in;
   logic [TIMER_BITS-1:0] linger_ff, linger_in;
   logic [2:0]            run_ff, run_in;
   result_type            res_ff, res_in;

   logic [31:0]           hold_wide;
   logic [TIMER_BITS-1:0] hold;
   logic [TIMER_BITS-1:0] t4_tmr;
   logic [T2_W:0]         dbl;
   logic [T2_W-1:0]       next_interval;

   // 64 * t1 saturated to the timer width
   assign hold_wide = {14'd0, cfg.t1_ms, 6'd0};
   assign hold      = (hold_wide > TMAX) ? TMAX[TIMER_BITS-1:0]
                                         : hold_wide[TIMER_BITS-1:0];
   assign t4_tmr    = TIMER_BITS'(cfg.t4_ms);
   assign dbl       = {interval_ff, 1'b0};
   assign next_interval = (dbl < {1'b0, cfg.t2_ms}) ? dbl[T2_W-1:0] : cfg.t2_ms;

   always_comb begin
      logic      inv;
      logic      prov;
      logic      term;
      phase_type p;

      inv  = cfg.is_invite;
      prov = (status_code >= 10'd100) && (status_code <= 10'd199);
      term = 1'b0;
      p    = phase_ff;
      if (inv && p == PH_NI_PROCEEDING) p = PH_PROCEEDING;
      if (!inv && p == PH_CONFIRMED && !ended_ff) p = PH_COMPLETED;

      phase_in    = phase_ff;
      ended_in    = ended_ff;
      prov_in     = prov_ff;
      final_in    = final_ff;
      interval_in = interval_ff;
      remain_in   = remain_ff;
      abandon_in  = abandon_ff;
      linger_in   = linger_ff;
      run_in      = run_ff;
      res_in      = '0;

      unique case (operation)
         OP_TICK: begin
            if (!ended_ff) begin
               if (run_ff[TMR_H]) begin
                  if (abandon_ff <= TIMER_BITS'(1)) begin
                     res_in.failed = 1'b1;
                     term = 1'b1;
                  end else begin
                     abandon_in = abandon_ff - TIMER_BITS'(1);
                  end
               end
               if (!term && run_ff[TMR_L]) begin
                  if (linger_ff <= TIMER_BITS'(1)) begin
                     term = 1'b1;
                  end else begin
                     linger_in = linger_ff - TIMER_BITS'(1);
                  end
               end
               if (!term && run_ff[TMR_G]) begin
                  if (remain_ff <= T2_W'(1)) begin
                     res_in.send_kind = SEND_FINAL;
                     res_in.send_code = final_ff;
                     interval_in = next_interval;
                     remain_in   = next_interval;
                  end else begin
                     remain_in = remain_ff - T2_W'(1);
                  end
               end
            end
         end
         OP_RESPOND: begin
            if (status_code == '0) begin
               // no response given
            end else if (ended_ff || status_code < 10'd100 || status_code > 10'd699 ||
                         p == PH_COMPLETED || p == PH_CONFIRMED) begin
               res_in.discarded = 1'b1;
            end else begin
               res_in.send_kind = SEND_GIVEN;
               res_in.send_code = status_code;
               if (prov) begin
                  prov_in = status_code;
                  if (!inv) phase_in = PH_NI_PROCEEDING;
               end else begin
                  final_in = status_code;
                  if (inv && status_code <= 10'd299) begin
                     term = 1'b1;
                  end else begin
                     phase_in = PH_COMPLETED;
                     if (inv) begin
                        abandon_in    = hold;
                        run_in[TMR_H] = 1'b1;
                        if (cfg.unreliable_transport) begin
                           interval_in   = T2_W'(cfg.t1_ms);
                           remain_in     = T2_W'(cfg.t1_ms);
                           run_in[TMR_G] = 1'b1;
                        end
                     end else begin
                        linger_in     = cfg.unreliable_transport ? hold : '0;
                        run_in[TMR_L] = 1'b1;
                     end
                  end
               end
            end
         end
         OP_RETRANS: begin
            if (ended_ff || (inv && p == PH_CONFIRMED) || (!inv && p == PH_PROCEEDING)) begin
               res_in.discarded = 1'b1;
            end else if (p == PH_COMPLETED) begin
               res_in.send_kind = SEND_FINAL;
               res_in.send_code = final_ff;
            end else if (prov_ff != '0) begin
               res_in.send_kind = SEND_PROV;
               res_in.send_code = prov_ff;
            end
         end
         OP_ACK: begin
            if (ended_ff || !inv || p == PH_PROCEEDING) begin
               res_in.discarded = 1'b1;
            end else if (p == PH_COMPLETED) begin
               // confirmed: timer i takes over
               phase_in      = PH_CONFIRMED;
               run_in        = '0;
               run_in[TMR_L] = 1'b1;
               remain_in     = '0;
               abandon_in    = '0;
               linger_in     = cfg.unreliable_transport ? t4_tmr : '0;
            end
         end
         OP_RESTART: begin
            phase_in    = PH_PROCEEDING;
            ended_in    = 1'b0;
            prov_in     = '0;
            final_in    = '0;
            interval_in = '0;
            remain_in   = '0;
            abandon_in  = '0;
            linger_in   = '0;
            run_in      = '0;
         end
         default: res_in.discarded = 1'b1;
      endcase

      if (term) begin
         phase_in   = PH_CONFIRMED;
         ended_in   = 1'b1;
         run_in     = '0;
         remain_in  = '0;
         abandon_in = '0;
         linger_in  = '0;
         res_in.terminated_now = 1'b1;
      end

      res_in.txn_phase     = ended_in ? PHASE_W'(PH_CONFIRMED) : PHASE_W'(phase_in);
      res_in.is_terminated = ended_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PROCEEDING;
         ended_ff    <= 1'b0;
         prov_ff     <= '0;
         final_ff    <= '0;
         interval_ff <= '0;
         remain_ff   <= '0;
         abandon_ff  <= '0;
         linger_ff   <= '0;
         run_ff      <= '0;
      end else if (load) begin
         phase_ff    <= phase_in;
         ended_ff    <= ended_in;
         prov_ff     <= prov_in;
         final_ff    <= final_in;
         interval_ff <= interval_in;
         remain_ff   <= remain_in;
         abandon_ff  <= abandon_in;
         linger_ff   <= linger_in;
         run_ff      <= run_in;
         res_ff      <= res_in;
      end
   end

   assign result = res_ff;

   a_ended_no_timers: assert property (@(posedge clock) disable iff (reset)
      ended_ff |-> (run_ff == '0))
      else $error("timer still running after termination");

   a_ended_phase: assert property (@(posedge clock) disable iff (reset)
      ended_ff |-> (phase_ff == PH_CONFIRMED))
      else $error("terminated with a live phase");

   a_fail_ends: assert property (@(posedge clock) disable iff (reset)
      load |=> (!res_ff.failed || (res_ff.terminated_now && res_ff.is_terminated)))
      else $error("failure reported without termination");

   a_discard_silent: assert property (@(posedge clock) disable iff (reset)
      load |=> (!res_ff.discarded || res_ff.send_kind == SEND_NONE))
      else $error("discarded event still sends");

endmodule

>>> design/sip_server_transaction_fsm_core.sv
// top level of the sip server transaction block
//
//   channel | direction | handshake     | payload
//   req     | in        | valid / ready | operation, status_code
//   rsp     | out       | valid / ready | send_kind, send_code, txn_phase, flags
//   csr     | in        | apb write     | is_invite, unreliable_transport, t1/t2/t4
//
// one beat in per cycle sustained while rsp is not stalled; an accepted beat is held in the input register
// then goes through one update into the result register, from which it is offered on rsp
// reset clears the handshake and transaction state, settings return to their defaults
// a stalled rsp holds its beat while the next req beat waits in the input register
`timescale 1ns / 1ps

module sip_server_transaction_fsm_core import sstf_pkg::*; #(
   parameter int TIMER_BITS = 18
) (
   input  logic              clock,
   input  logic              reset,
   sstf_req_if.sink          req,
   sstf_rsp_if.source        rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type           cfg;
   result_type        result;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [OP_W-1:0]   op_ff;
   logic [CODE_W-1:0] code_ff;

   // result register occupancy
   logic              out_valid_ff, out_valid_in;

   logic              advance;
   logic              load;
   logic              take;

   sstf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // result slot frees up when empty or being drained
   assign advance   = !out_valid_ff || rsp.ready;
   // held beat moves through the update into the result register
   assign load      = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      in_valid_in  = take ? 1'b1 : (load ? 1'b0 : in_valid_ff);
      out_valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload capture, no reset needed
   always_ff @(posedge clock) begin
      if (take) begin
         op_ff   <= req.operation;
         code_ff <= req.status_code;
      end
   end

   sstf_engine #(
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .operation   (op_ff),
      .status_code (code_ff),
      .cfg         (cfg),
      .result      (result)
   );

   assign rsp.valid          = out_valid_ff;
   assign rsp.send_kind      = result.send_kind;
   assign rsp.send_code      = result.send_code;
   assign rsp.txn_phase      = result.txn_phase;
   assign rsp.is_terminated  = result.is_terminated;
   assign rsp.terminated_now = result.terminated_now;
   assign rsp.failed         = result.failed;
   assign rsp.discarded      = result.discarded;

   a_load_fills: assert property (@(posedge clock) disable iff (reset)
      load |=> out_valid_ff)
      else $error("update lost its result beat");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req.ready)
      else $error("empty input register refuses a beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |-> !load)
      else $error("stalled result beat overwritten");

endmodule
